/* rtl/core/priority_sorted_cancel_arbiter_assert.svh */
`ifndef PRIORITY_SORTED_CANCEL_ARBITER_ASSERT_SVH
`define PRIORITY_SORTED_CANCEL_ARBITER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define PSCA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("arbiter check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define PSCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("arbiter check failed");

`endif

/* rtl/core/psca_pkg.sv */
package psca_pkg;

    localparam int MAX_ENTRIES_DEF   = 16;
    localparam int PRIORITY_BITS_DEF = 8;

    localparam int TAG_W    = 4;
    localparam int PRIO_W   = 8;
    localparam int MASK_W   = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEARCH
    } psca_state_t;

    typedef struct packed {
        logic             vld;
        logic             found;
        logic [TAG_W-1:0] tag;
    } srch_tok_t;

endpackage

/* rtl/core/psca_cell.sv */
module psca_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter int PW  = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [CW-1:0]             count,
    input  logic                      ins_en,
    input  logic [psca_pkg::TAG_W-1:0] ins_tag,
    input  logic [PW-1:0]             ins_prio,
    input  logic                      left_grt,
    input  logic [psca_pkg::TAG_W-1:0] left_tag,
    input  logic [PW-1:0]             left_prio,
    output logic                      grt,
    output logic [psca_pkg::TAG_W-1:0] tag,
    output logic [PW-1:0]             prio,
    input  logic [psca_pkg::MASK_W-1:0] mask,
    input  psca_pkg::srch_tok_t       tok_in,
    output psca_pkg::srch_tok_t       tok_out
);
    import psca_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [PW-1:0]    prio_reg, prio_next;
    srch_tok_t        tok_reg, tok_next;
    logic             occ;
    logic             at_end;
    logic             hit;

    assign occ    = IDX_C < count;
    assign at_end = count == IDX_C;
    assign grt    = occ && (ins_prio < prio_reg);
    assign hit    = occ && mask[tag_reg];

    always_comb begin
        tag_next  = tag_reg;
        prio_next = prio_reg;
        if (ins_en) begin
            if (left_grt) begin
                tag_next  = left_tag;
                prio_next = left_prio;
            end else if (grt || at_end) begin
                tag_next  = ins_tag;
                prio_next = ins_prio;
            end
        end
    end

    always_comb begin
        tok_next.vld   = tok_in.vld;
        tok_next.found = tok_in.found || hit;
        tok_next.tag   = tok_in.found ? tok_in.tag : (hit ? tag_reg : '0);
    end

    always_ff @(posedge aclk) begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tag     = tag_reg;
    assign prio    = prio_reg;
    assign tok_out = tok_reg;

endmodule

/* rtl/core/priority_sorted_cancel_arbiter.sv */
// Register and clear beats give their result beat in the cycle after acceptance.
// A cancel beat gives its result once the search token, registered first in tok0_reg,
// has walked the cell chain one cell per cycle and left the last cell.
// One beat is in work at a time; the next is taken once no cancel search is running and the result register is free.
// Reset clears the entry count, the controller and the output valid; entry contents
// are not cleared and are only read below the count.
module priority_sorted_cancel_arbiter #(
    parameter int MAX_ENTRIES   = psca_pkg::MAX_ENTRIES_DEF,
    parameter int PRIORITY_BITS = psca_pkg::PRIORITY_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // consumer_tag[3:0], priority_req[11:4], probes_present[12], active_mask[28:13]
    input  logic [psca_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  logic [psca_pkg::CMD_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], found[2], chosen_tag[6:3], consumer_count[11:7]
    output logic [psca_pkg::M_TDATA_W-1:0] m_tdata
);
    import psca_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    psca_state_t state_reg, state_next;

    logic [CW-1:0]       count_reg, count_next;
    logic [MASK_W-1:0]   mask_reg;
    srch_tok_t           tok0_reg, tok0_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                found_reg, found_next;
    logic [TAG_W-1:0]    chosen_reg, chosen_next;
    logic [CW-1:0]       cnt_out_reg, cnt_out_next;

    logic [TAG_W-1:0]  in_tag;
    logic [PW-1:0]     in_prio;
    logic              in_probes;
    logic [MASK_W-1:0] in_mask;
    logic              accept;
    logic              full;
    logic              do_ins;
    logic              search_done;
    logic [CW+COUNT_W-1:0] cnt_ext;

    logic [TAG_W-1:0] cell_tag  [MAX_ENTRIES];
    logic [PW-1:0]    cell_prio [MAX_ENTRIES];
    logic             cell_grt  [MAX_ENTRIES];
    srch_tok_t        tok       [MAX_ENTRIES+1];

    assign in_tag    = s_tdata[3:0];
    assign in_prio   = s_tdata[4 +: PW];
    assign in_probes = s_tdata[12];
    assign in_mask   = s_tdata[28:13];

    assign accept      = s_tvalid && s_tready;
    assign full        = count_reg == MAX_C;
    assign do_ins      = accept && (s_tuser == CMD_REGISTER) && in_probes && !full;
    assign search_done = tok[MAX_ENTRIES].vld;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == CMD_CANCEL)) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (search_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (state_reg)
            ST_IDLE:   s_tready = !m_valid_reg || m_tready;
            ST_SEARCH: s_tready = 1'b0;
            default:   s_tready = 1'b0;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (do_ins) begin
            count_next = count_reg + CW'(1);
        end else if (accept && (s_tuser == CMD_CLEAR)) begin
            count_next = '0;
        end
    end

    always_comb begin
        tok0_next     = '0;
        tok0_next.vld = accept && (s_tuser == CMD_CANCEL);
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        found_next   = found_reg;
        chosen_next  = chosen_reg;
        cnt_out_next = cnt_out_reg;
        if (search_done) begin
            m_valid_next = 1'b1;
            status_next  = STATUS_OK;
            found_next   = tok[MAX_ENTRIES].found;
            chosen_next  = tok[MAX_ENTRIES].tag;
            cnt_out_next = count_reg;
        end else if (accept && (s_tuser != CMD_CANCEL)) begin
            m_valid_next = 1'b1;
            found_next   = 1'b0;
            chosen_next  = '0;
            cnt_out_next = count_next;
            if (s_tuser == CMD_REGISTER) begin
                priority if (!in_probes) begin
                    status_next = STATUS_MISSING;
                end else if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    status_next = STATUS_OK;
                end
            end else begin
                status_next = STATUS_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            tok0_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            tok0_reg    <= tok0_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == CMD_CANCEL)) begin
            mask_reg <= in_mask;
        end
        status_reg  <= status_next;
        found_reg   <= found_next;
        chosen_reg  <= chosen_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign tok[0] = tok0_reg;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic             l_grt;
        logic [TAG_W-1:0] l_tag;
        logic [PW-1:0]    l_prio;

        if (i == 0) begin : g_first
            assign l_grt  = 1'b0;
            assign l_tag  = '0;
            assign l_prio = '0;
        end else begin : g_rest
            assign l_grt  = cell_grt[i-1];
            assign l_tag  = cell_tag[i-1];
            assign l_prio = cell_prio[i-1];
        end

        psca_cell #(
            .IDX (i),
            .CW  (CW),
            .PW  (PW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .count     (count_reg),
            .ins_en    (do_ins),
            .ins_tag   (in_tag),
            .ins_prio  (in_prio),
            .left_grt  (l_grt),
            .left_tag  (l_tag),
            .left_prio (l_prio),
            .grt       (cell_grt[i]),
            .tag       (cell_tag[i]),
            .prio      (cell_prio[i]),
            .mask      (mask_reg),
            .tok_in    (tok[i]),
            .tok_out   (tok[i+1])
        );
    end

    assign cnt_ext  = {{COUNT_W{1'b0}}, cnt_out_reg};
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, cnt_ext[COUNT_W-1:0], chosen_reg, found_reg, status_reg};

endmodule

/* rtl/core/psca_chk.sv */
`include "priority_sorted_cancel_arbiter_assert.svh"

module psca_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [psca_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [psca_pkg::CMD_W-1:0]    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [psca_pkg::M_TDATA_W-1:0] m_tdata
);
    import psca_pkg::*;

    `PSCA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `PSCA_ASSERT_NOW(a_no_find_tag, m_tvalid && !m_tdata[2], m_tdata[6:3] == 4'd0)
    `PSCA_ASSERT_NEXT(a_cancel_busy, s_tvalid && s_tready && (s_tuser == CMD_CANCEL), !s_tready)
    `PSCA_ASSERT_NEXT(a_missing, s_tvalid && s_tready && (s_tuser == CMD_REGISTER) && !s_tdata[12], m_tvalid && (m_tdata[1:0] == STATUS_MISSING))
    `PSCA_ASSERT_NEXT(a_clear, s_tvalid && s_tready && (s_tuser == CMD_CLEAR), m_tvalid && (m_tdata[11:7] == 5'd0) && (m_tdata[1:0] == STATUS_OK))

endmodule

bind priority_sorted_cancel_arbiter psca_chk u_psca_chk (.*);
